// ===== rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and constants for the four-level feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_THREADS = 32;
  localparam int NUM_LEVELS  = 4;

  localparam int ID_W  = $clog2(MAX_THREADS);
  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int BP_W  = 8;

  localparam logic [BP_W-1:0] BOOST_PERIOD_RESET = BP_W'(10);

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_PREEMPT = 2'd1,
    CMD_YIELD   = 2'd2,
    CMD_BLOCK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [ID_W-1:0]  thread_id;
    logic [LVL_W-1:0] enqueue_level;
  } in_item_t;

  typedef struct packed {
    logic             running_valid;
    logic [ID_W-1:0]  running_id;
    logic [LVL_W-1:0] running_level;
    logic             boost_done;
  } out_item_t;

endpackage

// ===== rtl/mlfq_thread_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler_top
// one event per cycle; the out_strobe result is registered and follows start in the next cycle
// throughput one item every cycle, busy stays low; the receiver cannot stall
// all queue updates of an event settle in one pass through the comb logic
// sync reset: queues empty, nothing running, boost period back to 10
// link store has no reset, entries are written before they are followed
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mlfq_pkg::in_item_t                in_item,
  output logic                              out_strobe,
  output mlfq_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [mlfq_pkg::BP_W-1:0]         cfg_wdata
);
  import mlfq_pkg::*;

  // queue state
  logic [ID_W-1:0]  head_r [NUM_LEVELS];
  logic [ID_W-1:0]  tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];
  logic [ID_W-1:0]  head_nxt [NUM_LEVELS];
  logic [ID_W-1:0]  tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [NUM_LEVELS];

  // running thread and boost bookkeeping
  logic             run_valid_r, run_valid_nxt;
  logic [ID_W-1:0]  run_id_r, run_id_nxt;
  logic [LVL_W-1:0] run_level_r, run_level_nxt;
  logic [BP_W-1:0]  disp_cnt_r, disp_cnt_nxt;
  logic [BP_W-1:0]  boost_period_r;
  logic             boost_nxt;

  // next-link store, two write slots per event applied in order
  logic [ID_W-1:0]  link_r [MAX_THREADS];
  logic             w1_en, w2_en;
  logic [ID_W-1:0]  w1_addr, w2_addr, w1_data, w2_data;

  // result register
  logic             out_strobe_r;
  out_item_t        out_item_r;

  // total of queued entries before this event (boost keeps the total)
  logic [CNT_W+1:0] total_q;

  logic             accept;

  assign accept = start;   // never busy
  assign busy   = 1'b0;

  always_comb begin
    total_q = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      total_q = total_q + (CNT_W+2)'(cnt_r[k]);
    end
  end

  always_comb begin
    logic [ID_W-1:0]  h [NUM_LEVELS];
    logic [ID_W-1:0]  t [NUM_LEVELS];
    logic [CNT_W-1:0] c [NUM_LEVELS];
    logic             rv;
    logic             room;
    logic             schedule;
    logic [BP_W-1:0]  period;
    logic [BP_W:0]    disp_inc;
    logic [LVL_W-1:0] lv;
    logic [LVL_W-1:0] back;
    logic [LVL_W-1:0] sel;
    logic             found;
    logic [ID_W-1:0]  pick;
    logic [ID_W-1:0]  link_rd;

    for (int k = 0; k < NUM_LEVELS; k++) begin
      h[k] = head_r[k];
      t[k] = tail_r[k];
      c[k] = cnt_r[k];
    end
    rv            = run_valid_r;
    run_id_nxt    = run_id_r;
    run_level_nxt = run_level_r;
    disp_cnt_nxt  = disp_cnt_r;
    boost_nxt     = 1'b0;
    w1_en   = 1'b0;
    w1_addr = '0;
    w1_data = '0;
    w2_en   = 1'b0;
    w2_addr = '0;
    w2_data = '0;
    sel     = '0;
    found   = 1'b0;
    pick    = '0;
    link_rd = '0;
    back    = run_level_r;

    room     = (total_q < (CNT_W+2)'(MAX_THREADS));
    period   = (boost_period_r == '0) ? BP_W'(1) : boost_period_r;
    disp_inc = {1'b0, disp_cnt_r} + 1'b1;
    // level field already spans exactly the level range, id field the id range
    lv       = in_item.enqueue_level;

    // enqueue goes through the first write slot
    if (in_item.command == CMD_ENQUEUE && room) begin
      if (c[lv] != '0) begin
        w1_en   = 1'b1;
        w1_addr = t[lv];
        w1_data = in_item.thread_id;
      end else begin
        h[lv] = in_item.thread_id;
      end
      t[lv] = in_item.thread_id;
      c[lv] = c[lv] + 1'b1;
    end

    schedule = (in_item.command != CMD_ENQUEUE) || !run_valid_r;

    if (schedule) begin
      // periodic boost: level 1 merges behind level 0, the rest shift up
      if (disp_inc >= {1'b0, period}) begin
        boost_nxt = 1'b1;
        if (c[1] != '0) begin
          if (c[0] != '0) begin
            if (in_item.command == CMD_ENQUEUE) begin
              w2_en   = 1'b1;
              w2_addr = t[0];
              w2_data = h[1];
            end else begin
              w1_en   = 1'b1;
              w1_addr = t[0];
              w1_data = h[1];
            end
          end else begin
            h[0] = h[1];
          end
          t[0] = t[1];
          c[0] = c[0] + c[1];
        end
        for (int k = 1; k < NUM_LEVELS - 1; k++) begin
          h[k] = h[k+1];
          t[k] = t[k+1];
          c[k] = c[k+1];
        end
        h[NUM_LEVELS-1] = '0;
        t[NUM_LEVELS-1] = '0;
        c[NUM_LEVELS-1] = '0;
      end

      // running thread leaves the processor; preempt demotes one level, but not below the last
      if (in_item.command != CMD_ENQUEUE && run_valid_r) begin
        if (in_item.command == CMD_PREEMPT && run_level_r < LVL_W'(NUM_LEVELS - 1)) begin
          back = run_level_r + 1'b1;
        end
        if (in_item.command != CMD_BLOCK && room) begin
          if (c[back] != '0) begin
            w2_en   = 1'b1;
            w2_addr = t[back];
            w2_data = run_id_r;
          end else begin
            h[back] = run_id_r;
          end
          t[back] = run_id_r;
          c[back] = c[back] + 1'b1;
        end
        rv = 1'b0;
      end

      // dispatch the head of the most urgent non-empty level
      if (!rv) begin
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
          if (c[k] != '0) begin
            sel   = LVL_W'(k);
            found = 1'b1;
          end
        end
        pick = h[sel];
        // link read sees this event's writes, later slot first
        if (w2_en && w2_addr == pick) begin
          link_rd = w2_data;
        end else if (w1_en && w1_addr == pick) begin
          link_rd = w1_data;
        end else begin
          link_rd = link_r[pick];
        end
        if (found) begin
          rv            = 1'b1;
          run_id_nxt    = pick;
          run_level_nxt = sel;
          if (c[sel] > CNT_W'(1)) begin
            h[sel] = link_rd;
          end else begin
            h[sel] = '0;
            t[sel] = '0;
          end
          c[sel] = c[sel] - 1'b1;
          disp_cnt_nxt = (disp_inc >= {1'b0, period}) ? '0 : disp_inc[BP_W-1:0];
        end else begin
          run_id_nxt    = '0;
          run_level_nxt = '0;
        end
      end
    end

    for (int k = 0; k < NUM_LEVELS; k++) begin
      head_nxt[k] = h[k];
      tail_nxt[k] = t[k];
      cnt_nxt[k]  = c[k];
    end
    run_valid_nxt = rv;
  end

  // control and queue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
      run_valid_r    <= 1'b0;
      run_id_r       <= '0;
      run_level_r    <= '0;
      disp_cnt_r     <= '0;
      boost_period_r <= BOOST_PERIOD_RESET;
      out_strobe_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        boost_period_r <= cfg_wdata;
      end
      out_strobe_r <= accept;
      if (accept) begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
          head_r[k] <= head_nxt[k];
          tail_r[k] <= tail_nxt[k];
          cnt_r[k]  <= cnt_nxt[k];
        end
        run_valid_r <= run_valid_nxt;
        run_id_r    <= run_id_nxt;
        run_level_r <= run_level_nxt;
        disp_cnt_r  <= disp_cnt_nxt;
      end
    end
  end

  // result payload and link store, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.running_valid <= run_valid_nxt;
      out_item_r.running_id    <= run_valid_nxt ? run_id_nxt : '0;
      out_item_r.running_level <= run_valid_nxt ? run_level_nxt : '0;
      out_item_r.boost_done    <= boost_nxt;
      // later slot wins when both hit one entry
      if (w1_en && !(w2_en && w2_addr == w1_addr)) begin
        link_r[w1_addr] <= w1_data;
      end
      if (w2_en) begin
        link_r[w2_addr] <= w2_data;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  // every accepted event yields exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_strobe) else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !out_strobe) else $error("result without event");

  // queues never hold more entries than there are threads
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_q <= (CNT_W+2)'(MAX_THREADS)) else $error("queue total overflow");

  // a boost that dispatched restarts the dispatch count
  a_boost_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.boost_done && out_item.running_valid |-> disp_cnt_r == '0)
    else $error("dispatch count not restarted on boost");
`endif

endmodule
